/* hw/rtl/spq_pkg.sv */
`timescale 1ns / 1ps

package spq_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int PRIO_W = 2;
    localparam int POS_W  = 5;
    localparam int REQ_W  = 3;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 5;
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [REQ_W-1:0] REQ_PUSH   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 3'd1;
    localparam logic [REQ_W-1:0] REQ_GET    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RENAME = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RAISE  = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_BADPOS = 2'd3;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [DATA_W-1:0] payload;
    } entry_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        entry_t            data;
    } mem_wr_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_RD,
        S_ACC_RD,
        S_REM_RD,
        S_REM_WR,
        S_INS_CHK,
        S_INS_CMP,
        S_FINISH
    } state_t;

endpackage

/* hw/rtl/sorted_priority_queue_unit.sv */
`timescale 1ns / 1ps

// Sorted priority queue of DEPTH entries, highest priority first and in
// arrival order among equal priorities.
// The request channel (s_) carries one operation per transfer: the kind in
// s_tuser, payload, priority and 1-based position in s_tdata. Every request
// yields exactly one result transfer on the m_ channel, with the status in
// m_tuser and the read payload, its priority and the new occupancy in m_tdata.
// All entries live in one memory with a write port and a registered read
// port, and a small sequencer moves entries through it one at a time.
// s_tready is high only while the sequencer is idle, so requests are served
// one at a time; s_tready returns high in the same cycle that the previous
// result first shows on m_tvalid.
// The result sits in an output register; the next request is taken while it
// waits, and the sequencer holds its finished result until that register is
// free, so a stalled receiver only stalls the block after one more request.
// Reset (aresetn low, synchronous) empties the queue and drops any result.

module sorted_priority_queue_unit import spq_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], prio[33:32], position[38:34], zero
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_value[31:0], out_prio[33:32], occupancy[38:34], zero
    output logic [1:0]  m_tuser    // status[1:0]
);

    state_t state_reg, state_next;

    logic [REQ_W-1:0]  req_reg,   req_next;
    logic [DATA_W-1:0] val_reg,   val_next;
    logic [PRIO_W-1:0] prio_reg,  prio_next;
    logic [POS_W-1:0]  pos_reg,   pos_next;
    logic [CNT_W-1:0]  cnt_reg,   cnt_next;
    logic [CNT_W-1:0]  idx_reg,   idx_next;
    entry_t            ent_reg,   ent_next;
    logic [STAT_W-1:0] stat_reg,  stat_next;
    logic [DATA_W-1:0] oval_reg,  oval_next;
    logic [PRIO_W-1:0] oprio_reg, oprio_next;

    logic              m_tvalid_reg, m_tvalid_next;
    logic [39:0]       m_tdata_reg,  m_tdata_next;
    logic [1:0]        m_tuser_reg,  m_tuser_next;

    mem_wr_t           wr;
    logic [ADDR_W-1:0] rd_addr;
    entry_t            rd_data;

    logic              s_fire;
    logic              pos_ok;
    logic              is_full;
    logic              is_empty;
    logic              rem_more;
    logic              raise_up;
    logic              ins_shift;
    logic              out_free;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] idx_addr;
    logic [ADDR_W-1:0] idx_m1_addr;
    logic [PRIO_W-1:0] push_prio;

    spq_store u_store (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    assign pos_ok      = (pos_reg != '0) && (CMP_W'(pos_reg) <= CMP_W'(cnt_reg));
    assign is_full     = (cnt_reg == CNT_W'(DEPTH));
    assign is_empty    = (cnt_reg == '0);
    assign rem_more    = (idx_reg < cnt_reg);
    assign raise_up    = (prio_reg > rd_data.prio);
    assign ins_shift   = (rd_data.prio < ent_reg.prio);
    assign slot        = ADDR_W'(pos_reg - POS_W'(1));
    assign idx_addr    = idx_reg[ADDR_W-1:0];
    assign idx_m1_addr = ADDR_W'(idx_reg - CNT_W'(1));
    // A pushed priority of zero is stored as one, the lowest priority an entry holds.
    assign push_prio   = (prio_reg == '0) ? PRIO_W'(1) : prio_reg;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (req_reg)
                    REQ_PUSH:   state_next = is_full ? S_FINISH : S_INS_CHK;
                    REQ_POP:    state_next = is_empty ? S_FINISH : S_POP_RD;
                    REQ_GET, REQ_RENAME, REQ_RAISE:
                                state_next = pos_ok ? S_ACC_RD : S_FINISH;
                    default:    state_next = S_FINISH;
                endcase
            end
            S_POP_RD: state_next = S_REM_RD;
            S_ACC_RD: begin
                if (req_reg == REQ_RAISE && raise_up) begin
                    state_next = S_REM_RD;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_REM_RD: begin
                if (rem_more) begin
                    state_next = S_REM_WR;
                end else if (req_reg == REQ_RAISE) begin
                    state_next = S_INS_CHK;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_REM_WR:  state_next = S_REM_RD;
            S_INS_CHK: state_next = (idx_reg == '0) ? S_FINISH : S_INS_CMP;
            S_INS_CMP: state_next = ins_shift ? S_INS_CHK : S_FINISH;
            S_FINISH: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, memory port and result register.
    always_comb begin
        req_next      = req_reg;
        val_next      = val_reg;
        prio_next     = prio_reg;
        pos_next      = pos_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        ent_next      = ent_reg;
        stat_next     = stat_reg;
        oval_next     = oval_reg;
        oprio_next    = oprio_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        wr            = '0;
        rd_addr       = idx_addr;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    req_next   = s_tuser;
                    val_next   = s_tdata[31:0];
                    prio_next  = s_tdata[33:32];
                    pos_next   = s_tdata[38:34];
                    stat_next  = STAT_OK;
                    oval_next  = '0;
                    oprio_next = '0;
                end
            end
            S_DISPATCH: begin
                case (req_reg)
                    REQ_PUSH: begin
                        if (is_full) begin
                            stat_next = STAT_FULL;
                        end else begin
                            ent_next = '{prio: push_prio, payload: val_reg};
                            idx_next = cnt_reg;
                        end
                    end
                    REQ_POP: begin
                        if (is_empty) begin
                            stat_next = STAT_EMPTY;
                        end
                        rd_addr = '0;
                    end
                    REQ_GET, REQ_RENAME, REQ_RAISE: begin
                        if (!pos_ok) begin
                            stat_next = STAT_BADPOS;
                        end
                        rd_addr = slot;
                    end
                    default: ;
                endcase
            end
            S_POP_RD: begin
                oval_next  = rd_data.payload;
                oprio_next = rd_data.prio;
                idx_next   = CNT_W'(1);
            end
            S_ACC_RD: begin
                case (req_reg)
                    REQ_GET: begin
                        oval_next  = rd_data.payload;
                        oprio_next = rd_data.prio;
                    end
                    REQ_RENAME: begin
                        wr.en           = 1'b1;
                        wr.addr         = slot;
                        wr.data.prio    = rd_data.prio;
                        wr.data.payload = val_reg;
                    end
                    REQ_RAISE: begin
                        if (raise_up) begin
                            ent_next = '{prio: prio_reg, payload: rd_data.payload};
                            idx_next = CNT_W'(pos_reg);
                        end
                    end
                    default: ;
                endcase
            end
            S_REM_RD: begin
                // Close the gap one entry at a time; the count drops once done.
                if (!rem_more) begin
                    cnt_next = cnt_reg - CNT_W'(1);
                    idx_next = cnt_reg - CNT_W'(1);
                end
            end
            S_REM_WR: begin
                wr.en    = 1'b1;
                wr.addr  = idx_m1_addr;
                wr.data  = rd_data;
                idx_next = idx_reg + CNT_W'(1);
            end
            S_INS_CHK: begin
                // Walk from the tail toward the head looking for the insert slot.
                if (idx_reg == '0) begin
                    wr.en    = 1'b1;
                    wr.addr  = '0;
                    wr.data  = ent_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
                rd_addr = idx_m1_addr;
            end
            S_INS_CMP: begin
                wr.en   = 1'b1;
                wr.addr = idx_addr;
                if (ins_shift) begin
                    wr.data  = rd_data;
                    idx_next = idx_reg - CNT_W'(1);
                end else begin
                    wr.data  = ent_reg;
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {1'b0, OCC_W'(cnt_reg), oprio_reg, oval_reg};
                    m_tuser_next  = stat_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        val_reg     <= val_next;
        prio_reg    <= prio_next;
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        ent_reg     <= ent_next;
        stat_reg    <= stat_next;
        oval_reg    <= oval_next;
        oprio_reg   <= oprio_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hw/rtl/spq_store.sv */
`timescale 1ns / 1ps

module spq_store import spq_pkg::*; (
    input  logic              aclk,
    input  mem_wr_t           wr,
    input  logic [ADDR_W-1:0] rd_addr,
    output entry_t            rd_data
);

    entry_t entry_mem_reg [DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            entry_mem_reg[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= entry_mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
